[rtl/core/owned_resource_table_defines.svh]
// ---------------------------------------------------------------------------
// owned_resource_table assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef OWNED_RESOURCE_TABLE_DEFINES_SVH
`define OWNED_RESOURCE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ORT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ORT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ORT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ORT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/ort_pkg.sv]
// ---------------------------------------------------------------------------
// ort_pkg
// Shared types, codes and field layout for the owned resource table.
// ---------------------------------------------------------------------------
package ort_pkg;

    // input beat layout (lowest bit first)
    localparam int CMD_W      = 3;
    localparam int ID_W       = 16;
    localparam int WORD_W     = 32;
    localparam int CLIENT_W   = 8;
    localparam int IN_DATA_W  = 64;

    localparam int CMD_LO     = 0;
    localparam int ID_LO      = CMD_LO + CMD_W;
    localparam int WORD_LO    = ID_LO + ID_W;
    localparam int PRESENT_LO = WORD_LO + WORD_W;
    localparam int CLIENT_LO  = PRESENT_LO + 1;

    // output beat layout (lowest bit first)
    localparam int STATUS_W   = 3;
    localparam int NEW_ID_W   = 11;
    localparam int RDATA_W    = 32;
    localparam int TOTAL_W    = 12;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USED_W = STATUS_W + NEW_ID_W + RDATA_W + TOTAL_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_GET     = 3'd1,
        CMD_SET     = 3'd2,
        CMD_RESERVE = 3'd3,
        CMD_RELEASE = 3'd4,
        CMD_REL_ALL = 3'd5,
        CMD_LIST    = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 3'd0,
        STAT_NOT_OWNER    = 3'd1,
        STAT_NO_ID        = 3'd2,
        STAT_NOT_RESERVED = 3'd3,
        STAT_FULL         = 3'd4,
        STAT_NO_VALUE     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_WR,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch command fields, read entry at id
        logic walk_rd;  // read owner entry at walk index
        logic walk_wr;  // clear ownership if it matches, advance index
        logic exec;     // finish command, load result register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_is_rall;  // command on the input is release-all
        logic walk_more;   // walk index below entry count
        logic out_free;    // result register can take a new result
    } t_dp_status;

endpackage

[rtl/core/ort_ram.sv]
// ---------------------------------------------------------------------------
// ort_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
module ort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ort_ctrl.sv]
// ---------------------------------------------------------------------------
// ort_ctrl
// Command sequencer: single-entry commands, release-all walk, result handoff.
// ---------------------------------------------------------------------------
module ort_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ort_pkg::t_dp_status   i_status,
    output ort_pkg::t_ctrl_cmd    o_cmd
);

    ort_pkg::t_state r_state;
    ort_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ort_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ort_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.in_is_rall ? ort_pkg::S_WALK_RD : ort_pkg::S_EXEC;
                end
            end
            ort_pkg::S_WALK_RD: begin
                if (i_status.walk_more) begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = ort_pkg::S_WALK_WR;
                end else begin
                    n_state = ort_pkg::S_EXEC;
                end
            end
            ort_pkg::S_WALK_WR: begin
                o_cmd.walk_wr = 1'b1;
                n_state = ort_pkg::S_WALK_RD;
            end
            ort_pkg::S_EXEC: begin
                // hold here while the previous result is still unclaimed
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state = ort_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ort_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/ort_dp.sv]
// ---------------------------------------------------------------------------
// ort_dp
// Entry stores, entry count, ownership checks and the result register.
// ---------------------------------------------------------------------------
module ort_dp #(
    parameter int NUM_ENTRIES  = 1024,
    parameter int DATA_WIDTH   = 32,
    parameter int CLIENT_WIDTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ort_pkg::IN_DATA_W-1:0]   i_in_data,
    input  ort_pkg::t_ctrl_cmd              i_cmd,
    output ort_pkg::t_dp_status             o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ort_pkg::OUT_DATA_W-1:0]  o_out_data
);

    localparam int AW  = $clog2(NUM_ENTRIES);
    localparam int UW  = $clog2(NUM_ENTRIES + 1);
    localparam int DW  = DATA_WIDTH;
    localparam int CLW = CLIENT_WIDTH;
    localparam int OW  = CLW + 1;  // {held, client}

    // control state
    logic [UW-1:0]    r_used;
    logic [UW-1:0]    r_walk_idx;
    logic             r_out_valid;

    // input field split
    logic [ort_pkg::CMD_W-1:0]    w_cmd_bits;
    logic [ort_pkg::ID_W-1:0]     w_id;
    logic [ort_pkg::WORD_W-1:0]   w_word_in;
    logic [ort_pkg::CLIENT_W-1:0] w_client_in;
    logic                         w_present;
    logic [DW+ort_pkg::WORD_W-1:0]    w_word_ext;
    logic [CLW+ort_pkg::CLIENT_W-1:0] w_client_ext;
    logic                         w_id_ok;

    assign w_cmd_bits   = i_in_data[ort_pkg::CMD_LO +: ort_pkg::CMD_W];
    assign w_id         = i_in_data[ort_pkg::ID_LO +: ort_pkg::ID_W];
    assign w_word_in    = i_in_data[ort_pkg::WORD_LO +: ort_pkg::WORD_W];
    assign w_present    = i_in_data[ort_pkg::PRESENT_LO];
    assign w_client_in  = i_in_data[ort_pkg::CLIENT_LO +: ort_pkg::CLIENT_W];
    assign w_word_ext   = {{DW{1'b0}}, w_word_in};
    assign w_client_ext = {{CLW{1'b0}}, w_client_in};
    // negative ids are never valid
    assign w_id_ok      = !w_id[ort_pkg::ID_W-1] && (w_id < ort_pkg::ID_W'(r_used));

    // latched command
    ort_pkg::t_cmd    r_cmd;
    logic             r_id_ok;
    logic [AW-1:0]    r_addr;
    logic [DW-1:0]    r_word;
    logic             r_present;
    logic [CLW-1:0]   r_client;

    // result register
    logic [ort_pkg::STATUS_W-1:0] r_status;
    logic [ort_pkg::NEW_ID_W-1:0] r_new_id;
    logic [ort_pkg::RDATA_W-1:0]  r_rdata;
    logic [ort_pkg::TOTAL_W-1:0]  r_total;

    // RAM ports
    logic [DW-1:0]    w_data_q;
    logic [OW-1:0]    w_own_q;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic             w_data_we;
    logic [AW-1:0]    w_data_waddr;
    logic [DW-1:0]    w_data_wdata;
    logic             w_own_we;
    logic [AW-1:0]    w_own_waddr;
    logic [OW-1:0]    w_own_wdata;

    // exec decisions
    ort_pkg::t_status             n_status;
    logic [ort_pkg::NEW_ID_W-1:0] n_new_id;
    logic [ort_pkg::RDATA_W-1:0]  n_rdata;
    logic [ort_pkg::TOTAL_W-1:0]  n_total;
    logic                         x_data_we;
    logic [AW-1:0]                x_waddr;
    logic                         x_own_we;
    logic [OW-1:0]                x_own_wdata;
    logic                         x_used_inc;

    logic                         w_held;
    logic                         w_match;
    logic [DW+ort_pkg::RDATA_W-1:0] w_rdata_ext;

    assign w_held      = w_own_q[CLW];
    assign w_match     = (w_own_q[CLW-1:0] == r_client);
    assign w_rdata_ext = {{ort_pkg::RDATA_W{1'b0}}, w_data_q};

    assign w_re    = i_cmd.accept || i_cmd.walk_rd;
    assign w_raddr = i_cmd.walk_rd ? r_walk_idx[AW-1:0] : w_id[AW-1:0];

    ort_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_ENTRIES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (w_data_waddr),
        .i_wdata (w_data_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_data_q)
    );

    ort_ram #(
        .WIDTH (OW),
        .DEPTH (NUM_ENTRIES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_own_we),
        .i_waddr (w_own_waddr),
        .i_wdata (w_own_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_own_q)
    );

    always_comb begin
        n_status    = ort_pkg::STAT_OK;
        n_new_id    = '1;
        n_rdata     = '0;
        n_total     = '1;
        x_data_we   = 1'b0;
        x_waddr     = r_addr;
        x_own_we    = 1'b0;
        x_own_wdata = {1'b0, w_own_q[CLW-1:0]};
        x_used_inc  = 1'b0;
        case (r_cmd)
            ort_pkg::CMD_CREATE: begin
                x_waddr     = r_used[AW-1:0];
                x_own_wdata = '0;
                if (!r_present) begin
                    n_status = ort_pkg::STAT_NO_VALUE;
                end else if (r_used == UW'(NUM_ENTRIES)) begin
                    n_status = ort_pkg::STAT_FULL;
                end else begin
                    x_data_we  = 1'b1;
                    x_own_we   = 1'b1;
                    x_used_inc = 1'b1;
                    n_new_id   = ort_pkg::NEW_ID_W'(r_used);
                end
            end
            ort_pkg::CMD_GET, ort_pkg::CMD_SET, ort_pkg::CMD_RELEASE: begin
                if (!r_id_ok) begin
                    n_status = ort_pkg::STAT_NO_ID;
                end else if (!w_held) begin
                    n_status = ort_pkg::STAT_NOT_RESERVED;
                end else if (!w_match) begin
                    n_status = ort_pkg::STAT_NOT_OWNER;
                end else if (r_cmd == ort_pkg::CMD_GET) begin
                    n_rdata = w_rdata_ext[ort_pkg::RDATA_W-1:0];
                end else if (r_cmd == ort_pkg::CMD_SET) begin
                    x_data_we = 1'b1;
                end else begin
                    x_own_we = 1'b1;
                end
            end
            ort_pkg::CMD_RESERVE: begin
                x_own_wdata = {1'b1, r_client};
                if (!r_id_ok) begin
                    n_status = ort_pkg::STAT_NO_ID;
                end else if (w_held && !w_match) begin
                    n_status = ort_pkg::STAT_NOT_OWNER;
                end else begin
                    x_own_we = 1'b1;
                end
            end
            ort_pkg::CMD_LIST: begin
                n_total = ort_pkg::TOTAL_W'(r_used);
            end
            default: begin
                // release-all finished in the walk; unknown codes do nothing
            end
        endcase
    end

    assign w_data_we    = i_cmd.exec && x_data_we;
    assign w_data_waddr = x_waddr;
    assign w_data_wdata = r_word;

    // the walk drops ownership only where this client holds the entry
    assign w_own_we    = i_cmd.walk_wr ? (w_held && w_match) : (i_cmd.exec && x_own_we);
    assign w_own_waddr = i_cmd.walk_wr ? r_walk_idx[AW-1:0] : x_waddr;
    assign w_own_wdata = i_cmd.walk_wr ? {1'b0, w_own_q[CLW-1:0]} : x_own_wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd     <= ort_pkg::t_cmd'(w_cmd_bits);
            r_id_ok   <= w_id_ok;
            r_addr    <= w_id[AW-1:0];
            r_word    <= w_word_ext[DW-1:0];
            r_present <= w_present;
            r_client  <= w_client_ext[CLW-1:0];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_new_id <= n_new_id;
            r_rdata  <= n_rdata;
            r_total  <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_walk_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec && x_used_inc) begin
                r_used <= r_used + UW'(1);
            end
            if (i_cmd.accept) begin
                r_walk_idx <= '0;
            end else if (i_cmd.walk_wr) begin
                r_walk_idx <= r_walk_idx + UW'(1);
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.in_is_rall = (ort_pkg::t_cmd'(w_cmd_bits) == ort_pkg::CMD_REL_ALL);
    assign o_status.walk_more  = (r_walk_idx < r_used);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(ort_pkg::OUT_DATA_W - ort_pkg::OUT_USED_W){1'b0}},
                          r_total, r_rdata, r_new_id, r_status};

endmodule

[rtl/core/owned_resource_table.sv]
// ---------------------------------------------------------------------------
// owned_resource_table: owned data-word table, one result beat per command beat
// Create/get/set/reserve/release/list: accept, then execute; input waits until the result loads.
// Release-all: the walk reads each entry, then clears it where this client holds it.
// Sync active-low reset empties the table (count 0) and drops any pending result.
// ---------------------------------------------------------------------------
`include "owned_resource_table_defines.svh"

module owned_resource_table #(
    parameter int NUM_ENTRIES  = 1024,
    parameter int DATA_WIDTH   = 32,
    parameter int CLIENT_WIDTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cmd[2:0], entry_id[18:3], data_word[50:19], data_present[51], client[59:52], zero pad
    input  logic [ort_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[2:0], new_id[13:3], read_data[45:14], entry_total[57:46], zero pad
    output logic [ort_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    ort_pkg::t_ctrl_cmd  w_cmd;
    ort_pkg::t_dp_status w_status;
    logic                w_in_beat;

    assign w_in_beat = s_axis_tvalid && s_axis_tready;

    ort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ort_dp #(
        .NUM_ENTRIES  (NUM_ENTRIES),
        .DATA_WIDTH   (DATA_WIDTH),
        .CLIENT_WIDTH (CLIENT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    `ORT_ASSERT_IMP(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd), "two commands at once")
    `ORT_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, w_in_beat, !s_axis_tready, "still ready")
    `ORT_ASSERT_NXT(a_exec_loads_result, i_clk, i_rst_n, w_cmd.exec, m_axis_tvalid, "no result")
    `ORT_ASSERT_IMP(a_walk_order, i_clk, i_rst_n, w_cmd.walk_wr, $past(w_cmd.walk_rd), "no read")

endmodule

[tb/owned_resource_table_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owned_resource_table_tb
// Drives command beats into the owned data-word table and checks every
// result beat against a behavioral table model kept in the bench. Starts
// with hand-picked corner commands, then runs randomized reserve/access
// sessions mixed with stray commands, waits for every result, and ends
// with a shorter randomized run. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module owned_resource_table_tb;

    localparam int NUM_ENTRIES = 1024;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [ort_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

    // result beat field offsets, lowest bit first
    localparam int NEW_ID_LO = ort_pkg::STATUS_W;
    localparam int RDATA_LO  = NEW_ID_LO + ort_pkg::NEW_ID_W;
    localparam int TOTAL_LO  = RDATA_LO + ort_pkg::RDATA_W;

    typedef struct {
        logic [ort_pkg::CMD_W-1:0]    op;
        logic [ort_pkg::ID_W-1:0]     id;
        logic [ort_pkg::WORD_W-1:0]   word;
        logic                         present;
        logic [ort_pkg::CLIENT_W-1:0] client;
    } t_table_cmd;

    typedef struct {
        logic [ort_pkg::STATUS_W-1:0] status;
        logic [ort_pkg::NEW_ID_W-1:0] new_id;
        logic [ort_pkg::RDATA_W-1:0]  rdata;
        logic [ort_pkg::TOTAL_W-1:0]  total;
    } t_table_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // cmd, entry_id, data_word, data_present, client, zero pad
    logic [ort_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // status, new_id, read_data, entry_total, zero pad
    logic [ort_pkg::OUT_DATA_W-1:0] m_tdata;

    owned_resource_table #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .DATA_WIDTH  (ort_pkg::WORD_W),
        .CLIENT_WIDTH(ort_pkg::CLIENT_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // mirror of the table
    bit [ort_pkg::WORD_W-1:0]   tbl_word  [NUM_ENTRIES];
    bit                         tbl_held  [NUM_ENTRIES];
    bit [ort_pkg::CLIENT_W-1:0] tbl_owner [NUM_ENTRIES];
    int unsigned       used_count = 0;

    t_table_cmd   cmd_backlog[$];
    t_table_reply pending_replies[$];
    int           beats_queued = 0;
    int           beats_taken = 0;
    int unsigned  planned_count = 0;   // entry count once every queued beat has run
    int           mismatch_count = 0;
    int           cycle_count = 0;
    logic [ort_pkg::CLIENT_W-1:0] client_pool[4];

    int send_gap = 0;
    int send_calm = 0;
    int sink_hold = 0;
    int sink_calm = 0;
    int hold;

    // mostly zero, some short, a few long; occasional stretch with no gaps
    function automatic int draw_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_table_reply table_apply(input logic [ort_pkg::IN_DATA_W-1:0] beat);
        logic [ort_pkg::CMD_W-1:0]    op;
        logic [ort_pkg::ID_W-1:0]     id;
        logic [ort_pkg::WORD_W-1:0]   word;
        logic                         present;
        logic [ort_pkg::CLIENT_W-1:0] who;
        logic                         id_ok;
        int unsigned                  idx;
        t_table_reply                 r;
        op      = beat[ort_pkg::CMD_LO +: ort_pkg::CMD_W];
        id      = beat[ort_pkg::ID_LO +: ort_pkg::ID_W];
        word    = beat[ort_pkg::WORD_LO +: ort_pkg::WORD_W];
        present = beat[ort_pkg::PRESENT_LO];
        who     = beat[ort_pkg::CLIENT_LO +: ort_pkg::CLIENT_W];
        r.status = ort_pkg::STAT_OK;
        r.new_id = '1;
        r.rdata  = '0;
        r.total  = '1;
        idx   = id[ort_pkg::ID_W-2:0];
        id_ok = !id[ort_pkg::ID_W-1] && idx < used_count;
        case (op)
            ort_pkg::CMD_CREATE: begin
                if (!present) begin
                    r.status = ort_pkg::STAT_NO_VALUE;
                end else if (used_count >= NUM_ENTRIES) begin
                    r.status = ort_pkg::STAT_FULL;
                end else begin
                    tbl_word[used_count]  = word;
                    tbl_held[used_count]  = 1'b0;
                    tbl_owner[used_count] = '0;
                    r.new_id = ort_pkg::NEW_ID_W'(used_count);
                    used_count++;
                end
            end
            ort_pkg::CMD_GET, ort_pkg::CMD_SET, ort_pkg::CMD_RELEASE: begin
                if (!id_ok) r.status = ort_pkg::STAT_NO_ID;
                else if (!tbl_held[idx]) r.status = ort_pkg::STAT_NOT_RESERVED;
                else if (tbl_owner[idx] != who) r.status = ort_pkg::STAT_NOT_OWNER;
                else if (op == ort_pkg::CMD_GET) r.rdata = tbl_word[idx];
                else if (op == ort_pkg::CMD_SET) tbl_word[idx] = word;
                else tbl_held[idx] = 1'b0;
            end
            ort_pkg::CMD_RESERVE: begin
                if (!id_ok) begin
                    r.status = ort_pkg::STAT_NO_ID;
                end else if (tbl_held[idx] && tbl_owner[idx] != who) begin
                    r.status = ort_pkg::STAT_NOT_OWNER;
                end else begin
                    tbl_held[idx]  = 1'b1;
                    tbl_owner[idx] = who;
                end
            end
            ort_pkg::CMD_REL_ALL: begin
                for (int i = 0; i < used_count; i++)
                    if (tbl_held[i] && tbl_owner[i] == who) tbl_held[i] = 1'b0;
            end
            ort_pkg::CMD_LIST: r.total = ort_pkg::TOTAL_W'(used_count);
            default: ;
        endcase
        return r;
    endfunction

    task automatic field_check(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < 10)
                $display("%0d: %s expected %h got %h", cycle_count, what, want, got);
            mismatch_count++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                t_table_cmd c;
                c = cmd_backlog.pop_front();
                s_tdata  <= {4'b0, c.client, c.present, c.word, c.id, c.op};
                s_tvalid <= 1'b1;
                send_gap <= draw_gap(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls, mostly after a taken beat, now and then while idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if ((m_tvalid && m_tready) || (!m_tvalid && $urandom_range(0, 19) == 0)) begin
            hold = draw_gap(sink_calm);
            sink_hold <= hold;
            m_tready  <= (hold == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // predict on each input beat, compare on each result beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                pending_replies.push_back(table_apply(s_tdata));
                beats_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0d: result beat %h with nothing pending",
                                 cycle_count, m_tdata);
                    mismatch_count++;
                end else begin
                    t_table_reply want;
                    want = pending_replies.pop_front();
                    field_check("status", 32'(want.status),
                                32'(m_tdata[0 +: ort_pkg::STATUS_W]));
                    field_check("new_id", 32'(want.new_id),
                                32'(m_tdata[NEW_ID_LO +: ort_pkg::NEW_ID_W]));
                    field_check("read_data", want.rdata,
                                m_tdata[RDATA_LO +: ort_pkg::RDATA_W]);
                    field_check("entry_total", 32'(want.total),
                                32'(m_tdata[TOTAL_LO +: ort_pkg::TOTAL_W]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_cmd(input logic [ort_pkg::CMD_W-1:0] op,
                            input logic [ort_pkg::ID_W-1:0] id,
                            input logic [ort_pkg::WORD_W-1:0] word, input logic present,
                            input logic [ort_pkg::CLIENT_W-1:0] client);
        t_table_cmd c;
        c.op = op;
        c.id = id;
        c.word = word;
        c.present = present;
        c.client = client;
        cmd_backlog.push_back(c);
        beats_queued++;
        if (op == ort_pkg::CMD_CREATE && present && planned_count < NUM_ENTRIES)
            planned_count++;
    endtask

    function automatic logic [ort_pkg::CLIENT_W-1:0] pick_client();
        if ($urandom_range(0, 9) == 0) return ort_pkg::CLIENT_W'($urandom);
        return client_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [ort_pkg::ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (planned_count > 0 && r < 7)
            return ort_pkg::ID_W'($urandom_range(0, planned_count - 1));
        if (r == 7) return ort_pkg::ID_W'(planned_count);
        if (r == 8) return {1'b1, 15'($urandom)};
        return ort_pkg::ID_W'($urandom);
    endfunction

    task automatic random_phase(input int n);
        int done_cnt;
        int r;
        int steps;
        logic [ort_pkg::CMD_W-1:0]    op;
        logic [ort_pkg::CLIENT_W-1:0] c;
        logic [ort_pkg::ID_W-1:0]     id;
        done_cnt = 0;
        while (done_cnt < n) begin
            if (planned_count > 0 && $urandom_range(0, 9) < 6) begin
                // reserve, then work on the entry as its owner, with some foreign access
                c  = pick_client();
                id = ort_pkg::ID_W'($urandom_range(0, planned_count - 1));
                push_cmd(ort_pkg::CMD_RESERVE, id, $urandom, 1'($urandom), c);
                steps = $urandom_range(1, 4);
                for (int k = 0; k < steps; k++) begin
                    r = $urandom_range(0, 2);
                    op = (r == 0) ? ort_pkg::CMD_GET :
                         (r == 1) ? ort_pkg::CMD_SET : ort_pkg::CMD_RELEASE;
                    push_cmd(op, id, $urandom, 1'($urandom),
                             ($urandom_range(0, 99) < 15) ? pick_client() : c);
                end
                done_cnt += steps + 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 16) op = ort_pkg::CMD_CREATE;
                else if (r < 34) op = ort_pkg::CMD_GET;
                else if (r < 48) op = ort_pkg::CMD_SET;
                else if (r < 66) op = ort_pkg::CMD_RESERVE;
                else if (r < 78) op = ort_pkg::CMD_RELEASE;
                else if (r < 82) op = ort_pkg::CMD_REL_ALL;
                else if (r < 88) op = ort_pkg::CMD_LIST;
                else if (r < 90) op = CMD_UNUSED;
                else op = ort_pkg::CMD_W'($urandom);
                push_cmd(op, pick_id(), $urandom, $urandom_range(0, 9) != 0, pick_client());
                done_cnt++;
            end
        end
    endtask

    task automatic drain();
        while (!(beats_taken == beats_queued && pending_replies.size() == 0))
            @(negedge i_clk);
    endtask

    initial begin
        client_pool[0] = '0;
        client_pool[1] = '1;
        client_pool[2] = ort_pkg::CLIENT_W'($urandom);
        client_pool[3] = ort_pkg::CLIENT_W'($urandom);

        // corner cases on an empty and a tiny table
        push_cmd(ort_pkg::CMD_LIST,    16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_GET,     16'd0,    32'd0,         1'b1, 8'd0);
        push_cmd(ort_pkg::CMD_CREATE,  16'd0,    32'h1234_5678, 1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_CREATE,  16'd0,    32'h0000_0000, 1'b1, 8'd0);
        push_cmd(ort_pkg::CMD_CREATE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        push_cmd(ort_pkg::CMD_GET,     16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_SET,     16'd0,    32'hDEAD_BEEF, 1'b1, 8'd0);
        push_cmd(ort_pkg::CMD_RELEASE, 16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_RESERVE, 16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_GET,     16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_GET,     16'd0,    32'd0,         1'b0, 8'hFF);
        push_cmd(ort_pkg::CMD_RESERVE, 16'd0,    32'd0,         1'b0, 8'hFF);
        push_cmd(ort_pkg::CMD_RESERVE, 16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_SET,     16'd0,    32'hA5A5_5A5A, 1'b1, 8'd0);
        push_cmd(ort_pkg::CMD_GET,     16'd0,    32'd0,         1'b1, 8'd0);
        push_cmd(ort_pkg::CMD_RESERVE, 16'd1,    32'd0,         1'b1, 8'hFF);
        // set stores the word even without the present flag
        push_cmd(ort_pkg::CMD_SET,     16'd1,    32'h0F0F_F0F0, 1'b0, 8'hFF);
        push_cmd(ort_pkg::CMD_GET,     16'd1,    32'd0,         1'b0, 8'hFF);
        push_cmd(ort_pkg::CMD_RELEASE, 16'd1,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_REL_ALL, 16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_GET,     16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_RELEASE, 16'd1,    32'd0,         1'b0, 8'hFF);
        push_cmd(ort_pkg::CMD_GET,     16'h8000, 32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_RESERVE, 16'h7FFF, 32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_SET,     16'd2,    32'd0,         1'b1, 8'd0);
        push_cmd(CMD_UNUSED,           16'd0,    32'hFFFF_FFFF, 1'b1, 8'hFF);
        push_cmd(ort_pkg::CMD_LIST,    16'd0,    32'd0,         1'b0, 8'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drain();
        random_phase(600);
        // hold off until every result is back
        drain();

        // ids past the end of the table, then a short random run
        push_cmd(ort_pkg::CMD_CREATE,  16'd0,    32'hCAFE_0001, 1'b1, 8'd0);
        push_cmd(ort_pkg::CMD_CREATE,  16'd0,    32'hCAFE_0002, 1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_LIST,    16'd0,    32'd0,         1'b0, 8'd0);
        push_cmd(ort_pkg::CMD_RESERVE, 16'd1023, 32'd0,         1'b0, 8'h5A);
        push_cmd(ort_pkg::CMD_GET,     16'd1023, 32'd0,         1'b0, 8'h5A);
        push_cmd(ort_pkg::CMD_GET,     16'd1024, 32'd0,         1'b0, 8'h5A);
        random_phase(100);
        push_cmd(ort_pkg::CMD_REL_ALL, 16'd0,    32'd0,         1'b0, client_pool[2]);
        push_cmd(ort_pkg::CMD_LIST,    16'd0,    32'd0,         1'b0, 8'd0);

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
